FILE: rtl/point_set_diameter_threshold_assert.svh
// Assertion macros for the point set diameter block.
// Plain text header, taken in by the top level; depends on nothing else.
`ifndef POINT_SET_DIAMETER_THRESHOLD_ASSERT_SVH
`define POINT_SET_DIAMETER_THRESHOLD_ASSERT_SVH

// Check that a condition implies another one in the same cycle.
`define PSDT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another one in the next cycle.
`define PSDT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/psdt_pkg.sv
// Shared constants and types of the point set diameter block.
// Used by point_set_diameter_threshold; depends on nothing.
package psdt_pkg;

  // Store sizing
  localparam int MAX_VECTORS = 256;
  localparam int MAX_DIMS    = 16;
  localparam int STORE_DEPTH = MAX_VECTORS * MAX_DIMS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int TOTAL_W     = $clog2(STORE_DEPTH + 1);
  localparam int CNT_W       = $clog2(MAX_VECTORS + 1);
  localparam int DIM_W       = (MAX_DIMS > 1) ? $clog2(MAX_DIMS + 1) : 1;

  // Datapath widths
  localparam int COORD_W  = 16;
  localparam int SQ_W     = 2 * COORD_W;
  localparam int SUM_W    = SQ_W + $clog2(MAX_DIMS) + 1;
  localparam int ROOT_W   = SUM_W + 1;
  localparam int ROOT_TOP = ((SUM_W - 1) / 2) * 2;
  localparam int OUT_W    = 18;
  localparam int ALPHA_W  = 16;
  localparam int PROD_W   = OUT_W + ALPHA_W;
  localparam int OUT_DATA_W = ((2 * OUT_W + 7) / 8) * 8;
  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  // Configuration registers
  localparam int DIMS_REG_W  = 5;
  localparam int COUNT_REG_W = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [DIMS_REG_W-1:0]  DIMS_RESET  = 5'd2;
  localparam logic [COUNT_REG_W-1:0] COUNT_RESET = 9'd256;
  localparam logic [ALPHA_W-1:0]     ALPHA_RESET = 16'd26214;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIMENSIONS     = 2'd0,
    CFG_VECTOR_COUNT   = 2'd1,
    CFG_ALPHA_FRACTION = 2'd2
  } cfg_index_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PAIRS,
    ST_DRAIN,
    ST_ROOT,
    ST_SAT,
    ST_SCALE
  } state_e;

endpackage

FILE: rtl/point_set_diameter_threshold.sv
// Point set diameter and pivot threshold, top level.
// Depends on psdt_pkg, psdt_ram and point_set_diameter_threshold_assert.svh.
//
// Usage:
//   Coordinates (signed Q8.8) stream in on the s_axis channel, vector after
//   vector, one transfer per cycle while loading. After dimensions *
//   vector_count coordinates the block runs an all-pairs pass and sends one
//   result on m_axis: diameter (Q10.8, floor of the root of the largest
//   squared distance) and threshold = (diameter * alpha_fraction) >> 16.
//   After the last coordinate the shared squaring unit takes one coordinate
//   pair per cycle over all N*(N-1)/2 vector pairs and D dimensions, then
//   its pipeline drains, the root unit works out the root bit by bit, and
//   saturation and scaling follow. s_axis_tready and cfg_ready_o are low
//   during that pass.
//   Configuration writes go through the cfg channel while loading; they take
//   effect on the next coordinate.
//   Reset restores the default registers and empties the load count; the
//   vector store is not cleared, since only entries of the current set are
//   read. A stalled receiver holds the result in the output register;
//   loading of the next set goes on, and a finished pass waits for it.
module point_set_diameter_threshold
  import psdt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Coordinate stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [COORD_W-1:0]    s_axis_tdata,   // [15:0] coordinate
  // Result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // [17:0] diameter, [35:18] threshold
);

  // Configuration registers
  logic [DIMS_REG_W-1:0]  dims_q;
  logic [COUNT_REG_W-1:0] count_q;
  logic [ALPHA_W-1:0]     alpha_q;

  // Effective configuration
  logic [DIM_W-1:0]         dims_use;
  logic [CNT_W-1:0]         count_use;
  logic [DIM_W+CNT_W-1:0]   total_full;
  logic [TOTAL_W-1:0]       total;

  // Control
  state_e state_q, state_d;
  logic in_xfer, set_done, issue, pipe_empty, out_free, out_load;
  logic [ADDR_W-1:0]  load_count_q, load_count_d;
  logic [TOTAL_W-1:0] load_next;

  // Pair sequencer
  logic [CNT_W-1:0]  i_q, i_d, j_q, j_d;
  logic [DIM_W-1:0]  k_q, k_d;
  logic [ADDR_W-1:0] base_i_q, base_i_d, base_j_q, base_j_d;
  logic [ADDR_W-1:0] dims_addr, rd_addr_a, rd_addr_b;
  logic last_k, last_j, last_i, pair_end;

  // Squaring pipeline
  logic [COORD_W-1:0] rdata_a, rdata_b;
  logic v1_q, v2_q, v3_q, l1_q, l2_q, l3_q;
  logic [COORD_W:0]   diff;
  logic [COORD_W-1:0] absd, absd_q;
  logic [SQ_W-1:0]    sq_q;
  logic [SUM_W-1:0]   acc_q, best_q, pair_sum;

  // Root and scaling
  logic [ROOT_W-1:0] x_q, r_q, bit_q, r_plus_bit;
  logic [OUT_W-1:0]  diam_q, out_diam_q, out_thr_q;
  logic [PROD_W-1:0] prod;
  logic              m_valid_q;

  // Clamp the configuration into the supported range
  always_comb begin
    if (dims_q == '0) begin
      dims_use = DIM_W'(1);
    end else if (int'(dims_q) > MAX_DIMS) begin
      dims_use = DIM_W'(MAX_DIMS);
    end else begin
      dims_use = DIM_W'(dims_q);
    end
    if (int'(count_q) < 2) begin
      count_use = CNT_W'(2);
    end else if (int'(count_q) > MAX_VECTORS) begin
      count_use = CNT_W'(MAX_VECTORS);
    end else begin
      count_use = CNT_W'(count_q);
    end
  end

  assign total_full = {{CNT_W{1'b0}}, dims_use} * {{DIM_W{1'b0}}, count_use};
  assign total      = total_full[TOTAL_W-1:0];

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q  <= DIMS_RESET;
      count_q <= COUNT_RESET;
      alpha_q <= ALPHA_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_DIMENSIONS:     dims_q  <= cfg_data_i[DIMS_REG_W-1:0];
        CFG_VECTOR_COUNT:   count_q <= cfg_data_i[COUNT_REG_W-1:0];
        CFG_ALPHA_FRACTION: alpha_q <= cfg_data_i[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // Load counter
  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign load_next = TOTAL_W'(load_count_q) + TOTAL_W'(1);
  assign set_done  = (load_next >= total);

  always_comb begin
    load_count_d = load_count_q;
    if (in_xfer) begin
      load_count_d = set_done ? '0 : load_next[ADDR_W-1:0];
    end
  end

  // Pair sequencer: walk k within a pair, then j, then i
  assign dims_addr = ADDR_W'(dims_use);
  assign last_k    = (k_q == DIM_W'(dims_use - DIM_W'(1)));
  assign last_j    = (j_q == CNT_W'(count_use - CNT_W'(1)));
  assign last_i    = (i_q == CNT_W'(count_use - CNT_W'(2)));
  assign pair_end  = last_k && last_j && last_i;
  assign rd_addr_a = base_i_q + ADDR_W'(k_q);
  assign rd_addr_b = base_j_q + ADDR_W'(k_q);

  always_comb begin
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;
    base_i_d = base_i_q;
    base_j_d = base_j_q;
    if (state_q == ST_LOAD && in_xfer && set_done) begin
      i_d      = '0;
      j_d      = CNT_W'(1);
      k_d      = '0;
      base_i_d = '0;
      base_j_d = dims_addr;
    end else if (state_q == ST_PAIRS) begin
      if (!last_k) begin
        k_d = k_q + DIM_W'(1);
      end else begin
        k_d = '0;
        if (!last_j) begin
          j_d      = j_q + CNT_W'(1);
          base_j_d = base_j_q + dims_addr;
        end else begin
          i_d      = i_q + CNT_W'(1);
          j_d      = i_q + CNT_W'(2);
          base_i_d = base_i_q + dims_addr;
          base_j_d = base_i_q + dims_addr + dims_addr;
        end
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD:  if (in_xfer && set_done) state_d = ST_PAIRS;
      ST_PAIRS: if (pair_end) state_d = ST_DRAIN;
      ST_DRAIN: if (pipe_empty) state_d = ST_ROOT;
      ST_ROOT:  if (bit_q[0]) state_d = ST_SAT;
      ST_SAT:   state_d = ST_SCALE;
      ST_SCALE: if (out_free) state_d = ST_LOAD;
      default:  state_d = ST_LOAD;
    endcase
  end

  // State outputs
  always_comb begin
    s_axis_tready = (state_q == ST_LOAD);
    cfg_ready_o   = (state_q == ST_LOAD);
    issue         = (state_q == ST_PAIRS);
    pipe_empty    = !(v1_q || v2_q || v3_q);
    out_free      = !m_valid_q || m_axis_tready;
    out_load      = (state_q == ST_SCALE) && out_free;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      load_count_q <= '0;
      i_q          <= '0;
      j_q          <= '0;
      k_q          <= '0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      v3_q         <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      load_count_q <= load_count_d;
      i_q          <= i_d;
      j_q          <= j_d;
      k_q          <= k_d;
      v1_q         <= issue;
      v2_q         <= v1_q;
      v3_q         <= v2_q;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Vector store
  psdt_ram #(
    .WIDTH (COORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (in_xfer),
    .waddr_i   (load_count_q),
    .wdata_i   (s_axis_tdata),
    .raddr_a_i (rd_addr_a),
    .raddr_b_i (rd_addr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // Absolute difference of the two coordinates
  assign diff = {rdata_a[COORD_W-1], rdata_a} - {rdata_b[COORD_W-1], rdata_b};
  assign absd = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];

  // Squared sum of the current pair
  assign pair_sum = acc_q + SUM_W'(sq_q);

  // Root step operand
  assign r_plus_bit = r_q + bit_q;

  // Threshold product
  assign prod = PROD_W'(diam_q) * PROD_W'(alpha_q);

  // Accumulate, keep the largest sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      best_q <= '0;
    end else if (state_q == ST_LOAD && in_xfer && set_done) begin
      acc_q  <= '0;
      best_q <= '0;
    end else if (v3_q) begin
      if (l3_q) begin
        acc_q <= '0;
        if (pair_sum > best_q) begin
          best_q <= pair_sum;
        end
      end else begin
        acc_q <= pair_sum;
      end
    end
  end

  // Datapath payload registers
  always_ff @(posedge clk_i) begin
    base_i_q <= base_i_d;
    base_j_q <= base_j_d;
    l1_q     <= issue && last_k;
    l2_q     <= l1_q;
    l3_q     <= l2_q;
    absd_q   <= absd;
    sq_q     <= SQ_W'(absd_q) * SQ_W'(absd_q);

    // Start the root on the final sum, then refine it bit by bit in ST_ROOT
    if (state_q == ST_DRAIN && pipe_empty) begin
      x_q   <= ROOT_W'(best_q);
      r_q   <= '0;
      bit_q <= ROOT_W'(1) << ROOT_TOP;
    end else if (state_q == ST_ROOT) begin
      if (x_q >= r_plus_bit) begin
        x_q <= x_q - r_plus_bit;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end

    // Saturate the root to the output width
    if (state_q == ST_SAT) begin
      diam_q <= (r_q > ROOT_W'(OUT_MAX)) ? OUT_MAX : r_q[OUT_W-1:0];
    end

    // Scale and hand over to the output register
    if (out_load) begin
      out_diam_q <= diam_q;
      out_thr_q  <= prod[ALPHA_W +: OUT_W];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - 2 * OUT_W){1'b0}}, out_thr_q, out_diam_q};

  // Assertions
  `include "point_set_diameter_threshold_assert.svh"

  `PSDT_ASSERT_NXT(a_pass_start, clk_i, rst_ni, in_xfer && set_done,
    state_q == ST_PAIRS && best_q == '0 && k_q == '0, "pass did not start cleanly")
  `PSDT_ASSERT_IMP(a_pair_addr, clk_i, rst_ni, state_q == ST_PAIRS,
    rd_addr_a < rd_addr_b && TOTAL_W'(rd_addr_b) < total, "pair address out of set")
  `PSDT_ASSERT_IMP(a_root_drained, clk_i, rst_ni, state_q == ST_ROOT,
    !(v1_q || v2_q || v3_q), "root started before pipeline drained")

endmodule

FILE: rtl/psdt_ram.sv
// Generic simple dual-read RAM: one write port, two registered read ports.
// Stand-alone; no package dependency.
module psdt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [WIDTH-1:0]  rdata_a_o,
  output logic [WIDTH-1:0]  rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one entry, read two, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

FILE: tb/sv/point_set_diameter_threshold_tb.sv
// Self-checking testbench for the point set diameter and threshold block.
// Streams coordinate sets under changing register settings and checks every result
// against an internal predictor; depends on psdt_pkg and the block's RTL.
module point_set_diameter_threshold_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import psdt_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 7;
  localparam int ITEM_TARGET   = 1500;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 64;
  localparam int CYCLE_LIMIT   = 1_500_000;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
  localparam logic [COORD_W-1:0]   COORD_MIN     = 16'h8000;
  localparam logic [COORD_W-1:0]   COORD_MAX     = 16'h7FFF;
  localparam logic [COORD_W-1:0]   COORD_ZERO    = 16'h0000;
  localparam logic [COORD_W-1:0]   COORD_NEG_LSB = 16'hFFFF;

  typedef enum int {
    FILL_RANDOM,
    FILL_CORNERS,
    FILL_EXTREMES,
    FILL_REPEAT,
    FILL_NEAR
  } fill_style_e;

  typedef struct packed {
    logic [OUT_W-1:0] diameter;
    logic [OUT_W-1:0] threshold;
  } diameter_result_t;

  // DUT connections; the inputs are known from time zero
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = CFG_DIMENSIONS;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [COORD_W-1:0]    s_axis_tdata  = '0;   // [15:0] coordinate
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;         // [17:0] diameter, [35:18] threshold

  // Predictor state: register copies, coordinate store and fill level
  logic [DIMS_REG_W-1:0]  dims_reg  = DIMS_RESET;
  logic [COUNT_REG_W-1:0] count_reg = COUNT_RESET;
  logic [ALPHA_W-1:0]     alpha_reg = ALPHA_RESET;
  logic [COORD_W-1:0]     coord_store [STORE_DEPTH];
  int unsigned            stored_count = 0;

  // Stimulus and scoreboard bookkeeping
  logic [COORD_W-1:0] coord_backlog [$];
  diameter_result_t   expected_diameters [$];
  diameter_result_t   oldest_result;
  int unsigned        coords_queued = 0;
  int unsigned        coord_accepts = 0;
  int unsigned        accepts_seen  = 0;
  int unsigned        burst_left    = 1;
  int unsigned        gap_left      = 0;
  logic [15:0]        ready_pattern = '1;
  int unsigned        ready_cycle   = 0;
  int unsigned        cycle_count   = 0;
  int unsigned        mismatch_count = 0;

  point_set_diameter_threshold dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #(CLK_HALF) clk_i = 1'b1;
    #(CLK_HALF) clk_i = 1'b0;
  end

  task automatic report_mismatch(string note);
    $display("MISMATCH cycle %0d: %s", cycle_count, note);
    mismatch_count++;
  endtask

  function automatic int unsigned dims_used();
    if (dims_reg == 0) return 1;
    if (dims_reg > MAX_DIMS) return MAX_DIMS;
    return dims_reg;
  endfunction

  function automatic int unsigned count_used();
    if (count_reg < 2) return 2;
    if (count_reg > MAX_VECTORS) return MAX_VECTORS;
    return count_reg;
  endfunction

  // Largest squared distance over all unordered pairs of stored vectors
  function automatic longint unsigned widest_square_sum(int unsigned dims, int unsigned count);
    longint unsigned best;
    longint unsigned acc;
    longint          diff;
    best = 0;
    for (int unsigned a = 0; a < count; a++) begin
      for (int unsigned b = a + 1; b < count; b++) begin
        acc = 0;
        for (int unsigned k = 0; k < dims; k++) begin
          diff = longint'($signed(coord_store[a * dims + k]))
               - longint'($signed(coord_store[b * dims + k]));
          acc += diff * diff;
        end
        if (acc > best) best = acc;
      end
    end
    return best;
  endfunction

  // Bitwise integer square root, rounded down, saturated to the output width
  function automatic logic [OUT_W-1:0] floor_root(longint unsigned sq);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 19; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= sq) r = t;
    end
    if (r > OUT_MAX) return OUT_MAX;
    return r[OUT_W-1:0];
  endfunction

  // Store one accepted coordinate; close the set when the fill level reaches the total
  task automatic absorb_coordinate(logic [COORD_W-1:0] raw);
    int unsigned      dims;
    int unsigned      count;
    longint unsigned  prod;
    diameter_result_t res;
    dims  = dims_used();
    count = count_used();
    coord_store[stored_count % STORE_DEPTH] = raw;
    stored_count++;
    if (stored_count >= dims * count) begin
      stored_count = 0;
      res.diameter  = floor_root(widest_square_sum(dims, count));
      prod          = 64'(res.diameter) * 64'(alpha_reg);
      res.threshold = OUT_W'(prod >> ALPHA_W);
      expected_diameters.push_back(res);
    end
  endtask

  // Write one register and mirror it into the predictor on the transfer
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    case (idx)
      CFG_DIMENSIONS:     dims_reg  = value[DIMS_REG_W-1:0];
      CFG_VECTOR_COUNT:   count_reg = value[COUNT_REG_W-1:0];
      CFG_ALPHA_FRACTION: alpha_reg = value[ALPHA_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Random junk above the register width, which the block must drop
  function automatic logic [CFG_DATA_W-1:0] field_with_noise(int unsigned field,
                                                             int unsigned width);
    logic [CFG_DATA_W-1:0] v;
    v = CFG_DATA_W'(field);
    if ($urandom_range(0, 1) == 1)
      v |= CFG_DATA_W'($urandom) & ~((CFG_DATA_W'(1) << width) - 1);
    return v;
  endfunction

  task automatic queue_coord(logic [COORD_W-1:0] c);
    coord_backlog.push_back(c);
    coords_queued++;
  endtask

  // Queue coordinates at set positions start.. in the given pattern
  task automatic queue_coords(int unsigned n, int unsigned start, int unsigned dims,
                              fill_style_e style);
    logic [COORD_W-1:0] motif [MAX_DIMS];
    logic [COORD_W-1:0] base;
    logic [COORD_W-1:0] c;
    int unsigned        pos;
    foreach (motif[k]) motif[k] = COORD_W'($urandom);
    base = COORD_W'($urandom);
    for (int unsigned i = 0; i < n; i++) begin
      pos = start + i;
      case (style)
        FILL_CORNERS: c = ((pos / dims) % 2 == 1) ? COORD_MAX : COORD_MIN;
        FILL_EXTREMES: begin
          case ($urandom_range(0, 3))
            0:       c = COORD_MIN;
            1:       c = COORD_MAX;
            2:       c = COORD_ZERO;
            default: c = COORD_NEG_LSB;
          endcase
        end
        FILL_REPEAT: c = motif[pos % dims];
        FILL_NEAR:   c = base + COORD_W'($urandom_range(0, 31));
        default:     c = COORD_W'($urandom);
      endcase
      queue_coord(c);
    end
  endtask

  // Hold until every coordinate is taken and every result has come back
  task automatic wait_idle();
    forever begin
      @(posedge clk_i);
      if (coord_backlog.size() == 0 && expected_diameters.size() == 0) break;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Coordinate driver: bursts of random length separated by random gaps
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!(s_axis_tvalid && coord_accepts == accepts_seen)) begin
      accepts_seen = coord_accepts;
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (coord_backlog.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= coord_backlog[0];
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // Result receiver: rotate a stall pattern and reload it with a random one
  always @(negedge clk_i) begin
    if (ready_cycle % 64 == 0)
      ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom | $urandom);
    ready_cycle++;
    m_axis_tready <= ready_pattern[0];
    ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
  end

  // Monitor: predict on coordinate transfers, check on result transfers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_coordinate(s_axis_tdata);
        coord_backlog.delete(0);
        coord_accepts++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_diameters.size() == 0) begin
          report_mismatch($sformatf("unexpected result diameter %0d threshold %0d",
                                    m_axis_tdata[OUT_W-1:0], m_axis_tdata[2*OUT_W-1:OUT_W]));
        end else begin
          oldest_result = expected_diameters.pop_front();
          if (m_axis_tdata[OUT_W-1:0] != oldest_result.diameter)
            report_mismatch($sformatf("diameter %0d, expected %0d",
                                      m_axis_tdata[OUT_W-1:0], oldest_result.diameter));
          if (m_axis_tdata[2*OUT_W-1:OUT_W] != oldest_result.threshold)
            report_mismatch($sformatf("threshold %0d, expected %0d",
                                      m_axis_tdata[2*OUT_W-1:OUT_W], oldest_result.threshold));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("point_set_diameter_threshold_tb: errors");
      $finish;
    end
  end

  initial begin
    int unsigned dims_field;
    int unsigned count_field;
    int unsigned dims_eff;
    int unsigned total;
    int unsigned need;
    int unsigned sets;
    int unsigned phase;
    bit          big_set;
    fill_style_e style;
    logic [ALPHA_W-1:0] alpha_value;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Zero dims and count below two: extreme coordinates over two scalar vectors
    write_register(CFG_DIMENSIONS, 16'd0);
    write_register(CFG_VECTOR_COUNT, 16'd1);
    write_register(CFG_ALPHA_FRACTION, 16'hFFFF);
    queue_coord(COORD_MIN);
    queue_coord(COORD_MAX);
    wait_idle();

    // Identical vectors give zero for both outputs
    write_register(CFG_DIMENSIONS, 16'd3);
    write_register(CFG_VECTOR_COUNT, 16'd0);
    write_register(CFG_ALPHA_FRACTION, 16'd0);
    repeat (2) begin
      queue_coord(16'h0100);
      queue_coord(16'hFF00);
      queue_coord(COORD_MAX);
    end
    wait_idle();

    // Layout grows mid-set: stored coordinates are read under the new layout
    write_register(CFG_DIMENSIONS, 16'd2);
    write_register(CFG_VECTOR_COUNT, 16'd3);
    write_register(CFG_ALPHA_FRACTION, ALPHA_RESET);
    queue_coords(4, 0, 2, FILL_RANDOM);
    wait_idle();
    write_register(CFG_DIMENSIONS, 16'd1);
    write_register(CFG_VECTOR_COUNT, 16'd5);
    queue_coords(1, 4, 1, FILL_RANDOM);
    wait_idle();

    // Layout shrinks below the fill level: the next coordinate closes the set
    write_register(CFG_DIMENSIONS, 16'd2);
    write_register(CFG_VECTOR_COUNT, 16'd4);
    queue_coords(6, 0, 2, FILL_EXTREMES);
    wait_idle();
    write_register(CFG_DIMENSIONS, 16'd1);
    write_register(CFG_VECTOR_COUNT, 16'd2);
    write_register(CFG_SPARE_IDX, 16'($urandom));
    queue_coords(1, 6, 1, FILL_RANDOM);
    wait_idle();

    // Random phases; a few force the register extremes and the largest sets
    phase = 0;
    while (coords_queued < ITEM_TARGET) begin
      big_set = (phase == 2 || phase == 5);
      case (phase)
        1:       dims_field = MAX_DIMS;
        2:       dims_field = 1;
        4:       dims_field = $urandom_range(MAX_DIMS + 1, 31);
        5:       dims_field = 0;
        default: begin
          case ($urandom_range(0, 9))
            0:       dims_field = 0;
            1:       dims_field = $urandom_range(MAX_DIMS, 31);
            default: dims_field = $urandom_range(1, 5);
          endcase
        end
      endcase
      dims_eff = (dims_field == 0) ? 1 : (dims_field > MAX_DIMS) ? MAX_DIMS : dims_field;
      if (phase == 2)
        count_field = MAX_VECTORS;
      else if (phase == 5)
        count_field = $urandom_range(MAX_VECTORS + 1, 511);
      else if ($urandom_range(0, 7) == 0)
        count_field = $urandom_range(0, 1);
      else
        count_field = (dims_eff >= MAX_DIMS) ? $urandom_range(2, 4) : $urandom_range(2, 8);
      write_register(CFG_DIMENSIONS, field_with_noise(dims_field, DIMS_REG_W));
      write_register(CFG_VECTOR_COUNT, field_with_noise(count_field, COUNT_REG_W));

      if (phase == 1 || phase == 3 || $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 7))
          0:       alpha_value = '0;
          1:       alpha_value = '1;
          default: alpha_value = ALPHA_W'($urandom);
        endcase
        if (phase == 1) alpha_value = '1;
        if (phase == 3) alpha_value = '0;
        write_register(CFG_ALPHA_FRACTION, alpha_value);
      end
      if ($urandom_range(0, 5) == 0)
        write_register(CFG_SPARE_IDX, 16'($urandom));

      // First set completes whatever a previous phase left behind
      total = dims_used() * count_used();
      need  = (stored_count >= total) ? 1 : total - stored_count;
      sets  = big_set ? 1 : $urandom_range(1, 4);
      for (int unsigned s = 0; s < sets; s++) begin
        style = (phase == 1 && s == 0) ? FILL_CORNERS : fill_style_e'($urandom_range(0, 4));
        if (s == 0)
          queue_coords(need, stored_count, dims_eff, style);
        else
          queue_coords(total, 0, dims_eff, style);
      end
      if (!big_set && $urandom_range(0, 3) == 0)
        queue_coords($urandom_range(1, total - 1), 0, dims_eff,
                     fill_style_e'($urandom_range(0, 4)));
      wait_idle();
      phase++;
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_diameters.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_diameters.size()));
    if (mismatch_count == 0) begin
      $display("point_set_diameter_threshold_tb: clean");
    end else begin
      $display("point_set_diameter_threshold_tb: errors");
    end
    $finish;
  end

endmodule
